// ===== hdl/plasma_pixel_generator_macros.svh =====
// Assertion helpers for the checker file.
`ifndef PLASMA_PIXEL_GENERATOR_MACROS_SVH
`define PLASMA_PIXEL_GENERATOR_MACROS_SVH
// Property checked at every clock edge outside reset.
`define PPG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppg check failed");
// Consequent checked a fixed number of cycles after the antecedent.
`define PPG_ASSERT_AFTER(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("ppg latency check failed");
`endif

// ===== hdl/ppg_pkg.sv =====
package ppg_pkg;

  localparam int DEF_FRAME_WIDTH        = 640;
  localparam int DEF_FRAME_HEIGHT       = 480;
  localparam int DEF_SINE_TABLE_ENTRIES = 1024;

  localparam int PX_W    = 10;
  localparam int PY_W    = 9;
  localparam int FT_W    = 24;
  localparam int T_W     = FT_W + 4;   // time in Q16
  localparam int ANG_W   = 32;
  localparam int PHASE_W = 32;
  localparam int SIN_W   = 16;
  localparam int ROM_W   = 15;
  localparam int VAL_W   = 15;
  localparam int LVL_W   = 4;

  localparam int                 OFFSET_Q16   = 3277;
  localparam logic [29:0]        TURN_PER_RAD = 30'd683565276;
  localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam int                 LEVEL_SCALE  = 10;

  // t/3 and t/5 by reciprocal multiply, exact for t below 2^28
  localparam int          DIV_MUL_W = 29;
  localparam logic [28:0] DIV3_MUL  = 29'd357913942;
  localparam int          DIV3_SH   = 30;
  localparam logic [28:0] DIV5_MUL  = 29'd429496730;
  localparam int          DIV5_SH   = 31;

  typedef struct packed {
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;
    logic [FT_W-1:0] frame_time;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] plasma_value;
    logic [LVL_W-1:0]        red_level;
    logic [LVL_W-1:0]        green_level;
  } out_t;

  // Quarter-wave entry from a Q30 angle, Taylor series to the 11th power.
  function automatic logic [ROM_W-1:0] quarter_rom_f(input logic [63:0] ang);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    a2   = (ang * ang) >> 30;
    term = ang;
    sum  = ang;
    term = ((term * a2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 110;
    sum  = sum - term;
    sum  = (sum + 64'd32768) >> 16;
    if (sum > 64'd16384) begin
      sum = 64'd16384;
    end
    return ROM_W'(sum);
  endfunction

  // Q16 radians to Q0.32 turns, wrapping.
  function automatic logic [PHASE_W-1:0] phase_of(input logic signed [ANG_W-1:0] ang);
    logic signed [62:0] prod;
    prod = 63'(ang) * 63'($signed({1'b0, TURN_PER_RAD}));
    return prod[47:16];
  endfunction

endpackage

// ===== hdl/plasma_pixel_generator.sv =====
// Plasma pixel generator: one pixel in, one plasma value and two color levels out.
// R_W is the root width (23 at the default frame); the pipeline depth grows with it
// through the radius square root stages.
// Throughput is one pixel per cycle; busy is low whenever reset is released.
// Synchronous active-low reset clears the valid pipeline; data registers are not reset.
module plasma_pixel_generator #(
  parameter int FRAME_WIDTH        = ppg_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT       = ppg_pkg::DEF_FRAME_HEIGHT,
  parameter int SINE_TABLE_ENTRIES = ppg_pkg::DEF_SINE_TABLE_ENTRIES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ppg_pkg::in_t  in_data,
  output logic          out_valid,
  output ppg_pkg::out_t out_data
);
  import ppg_pkg::*;

  localparam int QSTEPS = SINE_TABLE_ENTRIES / 4;

  // coordinate scaling by reciprocal multiply
  localparam int KX = 26 + $clog2(FRAME_WIDTH);
  localparam int KY = 26 + $clog2(FRAME_HEIGHT);
  localparam logic [63:0] MX = ((64'd1 << KX) + FRAME_WIDTH - 1) / FRAME_WIDTH;
  localparam logic [63:0] MY = ((64'd1 << KY) + FRAME_HEIGHT - 1) / FRAME_HEIGHT;
  localparam int MX_W = $clog2(MX + 1);
  localparam int MY_W = $clog2(MY + 1);
  localparam int XSH  = KX - 16;
  localparam int YSH  = KY - 16;
  localparam int XRAW_MAX = ((2 ** PX_W - 1) * 65536) / FRAME_WIDTH;
  localparam int YRAW_MAX = ((2 ** PY_W - 1) * 65536) / FRAME_HEIGHT;
  localparam int XB = $clog2(XRAW_MAX + 1);
  localparam int YB = $clog2(YRAW_MAX + 1);
  localparam int N_W = ((XB > YB) ? XB : YB) + 1;

  localparam int PRD_W  = N_W + SIN_W;
  localparam int OFS_W  = 13 + SIN_W;
  localparam int MIX_W  = N_W + 3;
  localparam int CX_W   = N_W + 1;
  localparam int RSQ_W0 = 2 * CX_W + 6;
  localparam int RSQ_W  = ((RSQ_W0 > 33) ? RSQ_W0 : 33) + 1;
  localparam int R_W    = (RSQ_W + 1) / 2;
  localparam int LAT    = 23 + R_W;

  function automatic logic [LVL_W-1:0] level_f(input logic signed [SIN_W-1:0] s);
    logic [SIN_W+3:0] prod;
    logic [LVL_W-1:0] lvl;
    prod = {4'b0000, s} * (SIN_W + 4)'(LEVEL_SCALE);
    if (s <= 0) begin
      lvl = '0;
    end else begin
      lvl = LVL_W'(prod >> 14);
    end
    return lvl;
  endfunction

  logic [LAT-1:0] vld_r;
  logic           accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  assign out_valid = vld_r[LAT-1];

  // stage 1: scaling products
  logic [T_W-1:0]           t_in;
  logic [PX_W+MX_W-1:0]     px_prod_r;
  logic [PY_W+MY_W-1:0]     py_prod_r;
  logic [T_W-1:0]           t1_r;
  logic [T_W+DIV_MUL_W-1:0] t3_prod_r;
  logic [T_W+DIV_MUL_W-1:0] t5_prod_r;

  assign t_in = {in_data.frame_time, 4'b0000};

  always_ff @(posedge clk) begin
    px_prod_r <= (PX_W + MX_W)'(in_data.pixel_x) * (PX_W + MX_W)'(MX);
    py_prod_r <= (PY_W + MY_W)'(in_data.pixel_y) * (PY_W + MY_W)'(MY);
    t1_r      <= t_in;
    t3_prod_r <= (T_W + DIV_MUL_W)'(t_in) * (T_W + DIV_MUL_W)'(DIV3_MUL);
    t5_prod_r <= (T_W + DIV_MUL_W)'(t_in) * (T_W + DIV_MUL_W)'(DIV5_MUL);
  end

  // stage 2: normalized coordinates, time fractions
  logic signed [N_W-1:0] xn2_r;
  logic signed [N_W-1:0] yn2_r;
  logic [T_W-1:0]        t2_2_r;
  logic [T_W-1:0]        t3_2_r;
  logic [T_W-1:0]        t5_2_r;
  logic [T_W-1:0]        t_2_r;

  always_ff @(posedge clk) begin
    xn2_r  <= $signed(N_W'(px_prod_r >> XSH)) - $signed(N_W'(OFFSET_Q16));
    yn2_r  <= $signed(N_W'(py_prod_r >> YSH)) - $signed(N_W'(OFFSET_Q16));
    t2_2_r <= {1'b0, t1_r[T_W-1:1]};
    t3_2_r <= T_W'(t3_prod_r >> DIV3_SH);
    t5_2_r <= T_W'(t5_prod_r >> DIV5_SH);
    t_2_r  <= t1_r;
  end

  // stage 3: phases of the time terms, first angle
  logic [PHASE_W-1:0]      ph_t2_3_r;
  logic [PHASE_W-1:0]      ph_t3_3_r;
  logic [PHASE_W-1:0]      ph_t5_3_r;
  logic signed [ANG_W-1:0] a1_3_r;

  always_ff @(posedge clk) begin
    ph_t2_3_r <= phase_of($signed(ANG_W'(t2_2_r)));
    ph_t3_3_r <= phase_of($signed(ANG_W'(t3_2_r)));
    ph_t5_3_r <= phase_of($signed(ANG_W'(t5_2_r)));
    a1_3_r    <= ANG_W'(xn2_r) * ANG_W'(10) + $signed(ANG_W'(t_2_r));
  end

  logic signed [SIN_W-1:0] st2_7;
  logic signed [SIN_W-1:0] ct3_7;
  logic signed [SIN_W-1:0] st5_7;

  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b0)) u_sin_t2 (
    .clk(clk), .phase(ph_t2_3_r), .sine(st2_7));
  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b1)) u_cos_t3 (
    .clk(clk), .phase(ph_t3_3_r), .sine(ct3_7));
  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b0)) u_sin_t5 (
    .clk(clk), .phase(ph_t5_3_r), .sine(st5_7));

  // stage 4: first wave phase
  logic [PHASE_W-1:0]      ph_a1_4_r;
  logic signed [SIN_W-1:0] s1_8;

  always_ff @(posedge clk) begin
    ph_a1_4_r <= phase_of(a1_3_r);
  end

  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b0)) u_sin_a1 (
    .clk(clk), .phase(ph_a1_4_r), .sine(s1_8));

  logic [2*N_W-1:0]      xy7;
  logic signed [N_W-1:0] xn7;
  logic signed [N_W-1:0] yn7;

  ppg_delay #(.W(2 * N_W), .D(5)) u_dly_xy (
    .clk(clk), .din({xn2_r, yn2_r}), .dout(xy7));

  assign xn7 = $signed(xy7[2*N_W-1:N_W]);
  assign yn7 = $signed(xy7[N_W-1:0]);

  // stage 8: wave and center products
  logic signed [PRD_W-1:0] mx_8_r;
  logic signed [PRD_W-1:0] my_8_r;
  logic signed [OFS_W-1:0] cxo_8_r;
  logic signed [OFS_W-1:0] cyo_8_r;
  logic signed [N_W-1:0]   xn8_r;
  logic signed [N_W-1:0]   yn8_r;

  always_ff @(posedge clk) begin
    mx_8_r  <= PRD_W'(xn7) * PRD_W'(st2_7);
    my_8_r  <= PRD_W'(yn7) * PRD_W'(ct3_7);
    cxo_8_r <= OFS_W'(OFFSET_Q16) * OFS_W'(st5_7);
    cyo_8_r <= OFS_W'(OFFSET_Q16) * OFS_W'(ct3_7);
    xn8_r   <= xn7;
    yn8_r   <= yn7;
  end

  // stage 9: mix and moving center (arithmetic shift = floor)
  logic signed [MIX_W-1:0] mix_9_r;
  logic signed [CX_W-1:0]  cx_9_r;
  logic signed [CX_W-1:0]  cy_9_r;
  logic [T_W-1:0]          t9;

  always_ff @(posedge clk) begin
    mix_9_r <= MIX_W'(mx_8_r >>> 14) + MIX_W'(my_8_r >>> 14);
    cx_9_r  <= CX_W'(xn8_r) + CX_W'(cxo_8_r >>> 14);
    cy_9_r  <= CX_W'(yn8_r) + CX_W'(cyo_8_r >>> 14);
  end

  ppg_delay #(.W(T_W), .D(7)) u_dly_t9 (
    .clk(clk), .din(t_2_r), .dout(t9));

  // stage 10: second angle, squares
  logic signed [ANG_W-1:0] a2_10_r;
  logic [2*CX_W-1:0]       cxsq_10_r;
  logic [2*CX_W-1:0]       cysq_10_r;

  always_ff @(posedge clk) begin
    a2_10_r   <= ANG_W'(mix_9_r) * ANG_W'(10) + $signed(ANG_W'(t9));
    cxsq_10_r <= (2 * CX_W)'((2 * CX_W)'(cx_9_r) * (2 * CX_W)'(cx_9_r));
    cysq_10_r <= (2 * CX_W)'((2 * CX_W)'(cy_9_r) * (2 * CX_W)'(cy_9_r));
  end

  // stage 11: second wave phase, radius square
  logic [PHASE_W-1:0] ph_a2_11_r;
  logic [RSQ_W-1:0]   rsq_11_r;
  logic [RSQ_W-1:0]   sumsq;

  assign sumsq = RSQ_W'(cxsq_10_r) + RSQ_W'(cysq_10_r);

  always_ff @(posedge clk) begin
    ph_a2_11_r <= phase_of(a2_10_r);
    rsq_11_r   <= sumsq * RSQ_W'(100) + (RSQ_W'(1) << 32);
  end

  logic signed [SIN_W-1:0] s2_15;
  logic [R_W-1:0]          root;
  logic [T_W-1:0]          t_rt;

  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b0)) u_sin_a2 (
    .clk(clk), .phase(ph_a2_11_r), .sine(s2_15));

  ppg_isqrt #(.R_W(R_W)) u_isqrt (
    .clk(clk), .radicand((2 * R_W)'(rsq_11_r)), .root(root));

  ppg_delay #(.W(T_W), .D(R_W + 2)) u_dly_trt (
    .clk(clk), .din(t9), .dout(t_rt));

  // radial wave angle and phase
  logic signed [ANG_W-1:0] a3_r;
  logic [PHASE_W-1:0]      ph_a3_r;
  logic signed [SIN_W-1:0] s3;
  logic [SIN_W-1:0]        s1_d;
  logic [SIN_W-1:0]        s2_d;

  always_ff @(posedge clk) begin
    a3_r    <= $signed(ANG_W'(root)) + $signed(ANG_W'(t_rt));
    ph_a3_r <= phase_of(a3_r);
  end

  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b0)) u_sin_a3 (
    .clk(clk), .phase(ph_a3_r), .sine(s3));

  ppg_delay #(.W(SIN_W), .D(R_W + 9)) u_dly_s1 (
    .clk(clk), .din(s1_8), .dout(s1_d));
  ppg_delay #(.W(SIN_W), .D(R_W + 2)) u_dly_s2 (
    .clk(clk), .din(s2_15), .dout(s2_d));

  // plasma value, then color sines
  logic signed [SIN_W+1:0] ssum;
  logic signed [VAL_W-1:0] value_r;
  logic [PHASE_W-1:0]      vphase;
  logic signed [SIN_W-1:0] vsin;
  logic signed [SIN_W-1:0] vcos;
  logic [VAL_W-1:0]        value_d;

  assign ssum = (SIN_W + 2)'($signed(s1_d)) + (SIN_W + 2)'($signed(s2_d))
              + (SIN_W + 2)'(s3);

  always_ff @(posedge clk) begin
    value_r <= VAL_W'(ssum >>> 2);
  end

  // value * pi as a phase: value in Q12 half turns
  assign vphase = {value_r[PHASE_W-20:0], 19'b0};

  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b0)) u_sin_v (
    .clk(clk), .phase(vphase), .sine(vsin));
  ppg_sine #(.QUARTER_STEPS(QSTEPS), .COS(1'b1)) u_cos_v (
    .clk(clk), .phase(vphase), .sine(vcos));

  ppg_delay #(.W(VAL_W), .D(4)) u_dly_val (
    .clk(clk), .din(value_r), .dout(value_d));

  out_t out_r;

  always_ff @(posedge clk) begin
    out_r.plasma_value <= $signed(value_d);
    out_r.red_level    <= level_f(vsin);
    out_r.green_level  <= level_f(vcos);
  end

  assign out_data = out_r;

endmodule

// ===== hdl/ppg_delay.sv =====
module ppg_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    tap_r[0] <= din;
    for (int i = 1; i < D; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[D-1];

endmodule

// ===== hdl/ppg_sine.sv =====
module ppg_sine #(
  parameter int QUARTER_STEPS = ppg_pkg::DEF_SINE_TABLE_ENTRIES / 4,
  parameter bit COS           = 1'b0
) (
  input  logic                              clk,
  input  logic [ppg_pkg::PHASE_W-1:0]       phase,
  output logic signed [ppg_pkg::SIN_W-1:0]  sine
);
  import ppg_pkg::*;

  localparam int STEPS  = 4 * QUARTER_STEPS;
  localparam int IDX_W  = $clog2(STEPS);
  localparam int ADDR_W = $clog2(QUARTER_STEPS + 1);
  localparam int MUL_W  = PHASE_W + $clog2(STEPS + 1);
  localparam logic [PHASE_W-1:0] PH_OFS = COS ? QUARTER_TURN : '0;

  // quarter-wave table, built at elaboration
  logic [ROM_W-1:0] tab [QUARTER_STEPS+1];
  for (genvar gi = 0; gi <= QUARTER_STEPS; gi++) begin : g_rom
    localparam logic [63:0]      ANG   = (HALF_PI_Q30 * gi) / QUARTER_STEPS;
    localparam logic [ROM_W-1:0] ROM_V = quarter_rom_f(ANG);
    assign tab[gi] = ROM_V;
  end

  logic [PHASE_W-1:0] ph;
  logic [MUL_W-1:0]   idx_prod;
  logic [IDX_W-1:0]   idx_r;
  logic [1:0]         quad;
  logic [IDX_W-1:0]   rem_idx;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [ADDR_W-1:0]  addr_r;
  logic               neg_b_r;
  logic               neg_c_r;
  logic [ROM_W-1:0]   rom_r;
  logic signed [SIN_W-1:0] sine_r;

  assign ph       = phase + PH_OFS;
  assign idx_prod = MUL_W'(ph) * MUL_W'(STEPS);

  always_comb begin
    if (idx_r >= IDX_W'(3 * QUARTER_STEPS)) begin
      quad    = 2'd3;
      rem_idx = idx_r - IDX_W'(3 * QUARTER_STEPS);
    end else if (idx_r >= IDX_W'(2 * QUARTER_STEPS)) begin
      quad    = 2'd2;
      rem_idx = idx_r - IDX_W'(2 * QUARTER_STEPS);
    end else if (idx_r >= IDX_W'(QUARTER_STEPS)) begin
      quad    = 2'd1;
      rem_idx = idx_r - IDX_W'(QUARTER_STEPS);
    end else begin
      quad    = 2'd0;
      rem_idx = idx_r;
    end
    if (quad[0]) begin
      addr_nxt = ADDR_W'(QUARTER_STEPS) - ADDR_W'(rem_idx);
    end else begin
      addr_nxt = ADDR_W'(rem_idx);
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= IDX_W'(idx_prod >> PHASE_W);
    addr_r  <= addr_nxt;
    neg_b_r <= quad[1];
    rom_r   <= tab[addr_r];
    neg_c_r <= neg_b_r;
    if (neg_c_r) begin
      sine_r <= -$signed({1'b0, rom_r});
    end else begin
      sine_r <= $signed({1'b0, rom_r});
    end
  end

  assign sine = sine_r;

endmodule

// ===== hdl/ppg_isqrt.sv =====
module ppg_isqrt #(
  parameter int R_W = 23
) (
  input  logic               clk,
  input  logic [2*R_W-1:0]   radicand,
  output logic [R_W-1:0]     root
);

  localparam int REM_W = R_W + 3;

  logic [2*R_W-1:0] rad_r  [R_W];
  logic [REM_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]   root_r [R_W];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar gi = 0; gi < R_W; gi++) begin : g_stage
    logic [2*R_W-1:0] rad_in;
    logic [REM_W-1:0] rem_in;
    logic [R_W-1:0]   root_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_nxt;
    logic [R_W-1:0]   root_nxt;

    if (gi == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[gi-1];
      assign rem_in  = rem_r[gi-1];
      assign root_in = root_r[gi-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[2*R_W-1 -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[R_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[R_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rad_r[gi]  <= rad_in << 2;
      rem_r[gi]  <= rem_nxt;
      root_r[gi] <= root_nxt;
    end
  end

  assign root = root_r[R_W-1];

endmodule

// ===== hdl/ppg_checker.sv =====
`include "plasma_pixel_generator_macros.svh"

module ppg_checker #(
  parameter int LAT = 46
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input ppg_pkg::out_t out_data,
  input logic          out_valid
);
  import ppg_pkg::*;

  logic [7:0] lvl_sq_sum;
  logic       value_zero;
  logic       levels_at_zero;

  assign lvl_sq_sum     = 8'(out_data.red_level) * 8'(out_data.red_level)
                        + 8'(out_data.green_level) * 8'(out_data.green_level);
  assign value_zero     = (out_data.plasma_value == '0);
  assign levels_at_zero = (out_data.red_level == 4'd0) && (out_data.green_level == 4'd10);

  // every transfer yields exactly one result, and no result appears without a transfer
  `PPG_ASSERT_AFTER(a_result_follows, start && !busy, LAT, out_valid)
  `PPG_ASSERT_AFTER(a_no_phantom, !(start && !busy), LAT, !out_valid)
  // truncated sine and cosine levels stay inside the circle of radius 10
  `PPG_ASSERT(a_level_circle, out_valid |-> (lvl_sq_sum <= 8'd100))
  `PPG_ASSERT(a_zero_value, (out_valid && value_zero) |-> levels_at_zero)

endmodule

bind plasma_pixel_generator ppg_checker #(.LAT(LAT)) u_ppg_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ppg_pkg::*;

  localparam int FRAME_W      = 640;
  localparam int FRAME_H      = 480;
  localparam int QSTEPS       = 256;
  localparam int PIPE_LAT     = 46;
  localparam int STALL_LIMIT  = 2000;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  in_t   in_data;
  logic  out_valid;
  out_t  out_data;

  out_t  pending_pixels[$];
  int    error_count;
  int    quiet_cycles;

  plasma_pixel_generator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------- plasma predictor ----------------
  function automatic longint quarter_wave(int r);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned sum;
    a    = 64'd1686629713 * longint'(r) / QSTEPS;
    a2   = (a * a) >> 30;
    term = a;
    sum  = a;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * a2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    sum = (sum + 64'd32768) >> 16;
    if (sum > 16384) sum = 16384;
    return longint'(sum);
  endfunction

  function automatic longint sine_at(bit [31:0] ph);
    bit [9:0] idx;
    int       quad;
    int       r;
    longint   v;
    idx  = ph[31:22];
    quad = idx / QSTEPS;
    r    = idx % QSTEPS;
    v    = (quad % 2 == 1) ? quarter_wave(QSTEPS - r) : quarter_wave(r);
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic bit [31:0] turns_of(longint a);
    longint unsigned p;
    p = longint'(a) * 64'd683565276;
    return p[47:16];
  endfunction

  function automatic longint unsigned root_of(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [3:0] level_from(longint s);
    longint l;
    if (s <= 0) return 4'd0;
    l = (10 * s) >>> 14;
    return l[3:0];
  endfunction

  function automatic out_t predict_pixel(in_t px);
    longint          t;
    longint          xn;
    longint          yn;
    longint          s1;
    longint          s2;
    longint          s3;
    longint          mix;
    longint          cx;
    longint          cy;
    longint          val;
    longint unsigned rsq;
    bit [31:0]       vph;
    out_t            res;
    t   = longint'(px.frame_time) << 4;
    xn  = (longint'(px.pixel_x) << 16) / FRAME_W - OFFSET_Q16;
    yn  = (longint'(px.pixel_y) << 16) / FRAME_H - OFFSET_Q16;
    s1  = sine_at(turns_of(10 * xn + t));
    mix = ((xn * sine_at(turns_of(t / 2))) >>> 14)
        + ((yn * sine_at(turns_of(t / 3) + QUARTER_TURN)) >>> 14);
    s2  = sine_at(turns_of(10 * mix + t));
    cx  = xn + ((longint'(OFFSET_Q16) * sine_at(turns_of(t / 5))) >>> 14);
    cy  = yn + ((longint'(OFFSET_Q16) * sine_at(turns_of(t / 3) + QUARTER_TURN)) >>> 14);
    rsq = 100 * (longint'(cx * cx) + longint'(cy * cy)) + (64'd1 << 32);
    s3  = sine_at(turns_of(longint'(root_of(rsq)) + t));
    val = (s1 + s2 + s3) >>> 2;
    vph = val[12:0] << 19;
    res.plasma_value = val[14:0];
    res.red_level    = level_from(sine_at(vph));
    res.green_level  = level_from(sine_at(vph + QUARTER_TURN));
    return res;
  endfunction

  // ---------------- result checker and watchdog ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        error_count++;
      end else begin
        out_t exp_px;
        exp_px = pending_pixels.pop_front();
        if (out_data.plasma_value !== exp_px.plasma_value) begin
          $error("plasma_value exp %0d got %0d", exp_px.plasma_value, out_data.plasma_value);
          error_count++;
        end
        if (out_data.red_level !== exp_px.red_level) begin
          $error("red_level exp %0d got %0d", exp_px.red_level, out_data.red_level);
          error_count++;
        end
        if (out_data.green_level !== exp_px.green_level) begin
          $error("green_level exp %0d got %0d", exp_px.green_level, out_data.green_level);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || (rst_n && out_valid) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_pixel(input logic [9:0] x, input logic [8:0] y, input logic [23:0] ft);
    in_t px;
    px.pixel_x    = x;
    px.pixel_y    = y;
    px.frame_time = ft;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(predict_pixel(px));
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_random(input bit in_frame);
    if (in_frame)
      send_pixel(10'($urandom_range(FRAME_W - 1)), 9'($urandom_range(FRAME_H - 1)),
                 24'($urandom));
    else
      send_pixel(10'($urandom_range(1023)), 9'($urandom_range(511)), 24'($urandom));
  endtask

  task automatic test_corners();
    logic [9:0]  xs[4] = '{10'd0, 10'd639, 10'd640, 10'd1023};
    logic [8:0]  ys[4] = '{9'd0, 9'd479, 9'd480, 9'd511};
    logic [23:0] ts[3] = '{24'd0, 24'hFFFFFF, 24'h800000};
    foreach (xs[i]) send_pixel(xs[i], ys[i], ts[i % 3]);
    foreach (ts[i]) send_pixel(10'd320, 9'd240, ts[i]);
    send_pixel(10'd0, 9'd511, 24'hFFFFFF);
    send_pixel(10'd1023, 9'd0, 24'd0);
    send_pixel(10'h2AA, 9'h155, 24'h555555);
    send_pixel(10'h155, 9'h0AA, 24'hAAAAAA);
    send_pixel(10'd1, 9'd1, 24'd1);
    // slow time sweep walks the plasma value through its range
    for (int i = 0; i < 10; i++) send_pixel(10'd100, 9'd50, 24'(i * 1609));
  endtask

  task automatic test_bursty(input int count);
    for (int i = 0; i < count; i++) begin
      send_random($urandom_range(9) != 0);
      if ($urandom_range(3) == 0) idle_for($urandom_range(1, 12));
    end
  endtask

  task automatic test_drain_pause();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (5) send_random(1'b1);
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) send_random($urandom_range(7) != 0);
    @(negedge clk);
    start <= 1'b0;
  endtask

  initial begin
    error_count  = 0;
    quiet_cycles = 0;
    start        = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_corners();
    test_bursty(200);
    test_drain_pause();
    test_bursty(100);
    test_back_to_back(120);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
